### rtl/mspp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SUBSCRIBE payload parser.
// Used by the front parser, the result queue, the output stage and the top level.
package mspp_pkg;

  localparam int unsigned LEN_W    = 28;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = QPTR_W + 1;

  localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};
  localparam logic [7:0]       QOS_MAX   = 8'h02;
  localparam logic [1:0]       QOS_ZERO  = 2'd0;

  typedef enum logic [2:0] {
    KIND_ID   = 3'd0,
    KIND_LEN  = 3'd1,
    KIND_CHAR = 3'd2,
    KIND_QOS  = 3'd3,
    KIND_IGN  = 3'd4
  } byte_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_PAYLOAD = 3'd1,
    ERR_ZERO_LEN   = 3'd2,
    ERR_OVERFLOW   = 3'd3,
    ERR_IGNORED    = 3'd4
  } error_e;

  typedef struct packed {
    byte_kind_e  kind;
    logic [7:0]  topic_char;
    logic        topic_last;
    logic [15:0] topic_length;
    logic [15:0] packet_id;
    logic [1:0]  qos_value;
    logic        qos_replaced;
    error_e      error_code;
    logic        packet_done;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/mspp_front.sv
`timescale 1ns / 1ps
// Front parser: accepts bytes, tracks the packet phase and classifies each byte.
// Depends on mspp_pkg for the result record and codes.
module mspp_front import mspp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             start_packet_i,
  input  logic [LEN_W-1:0] remaining_length_i,
  input  logic [7:0]       data_byte_i,
  output result_t          result_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ID_HI  = 3'd1,
    PH_ID_LO  = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_TOPIC  = 3'd5,
    PH_QOS    = 3'd6,
    PH_HALT   = 3'd7
  } phase_e;

  phase_e           phase_q, phase_d, phase_cur;
  logic [15:0]      field_cnt_q, field_cnt_d, field_cnt_cur;
  logic [LEN_W-1:0] consumed_q, consumed_d, consumed_cur, consumed_inc;
  logic [LEN_W-1:0] limit_q, limit_d;
  logic [7:0]       high_q, high_d, high_cur;
  logic [15:0]      id_q, id_d, id_cur;
  logic [15:0]      word;
  logic [15:0]      field_dec;
  logic             reached;

  // A start byte restarts from a clean packet context.
  always_comb begin
    phase_cur     = start_packet_i ? PH_ID_HI : phase_q;
    field_cnt_cur = start_packet_i ? 16'd0 : field_cnt_q;
    consumed_cur  = start_packet_i ? '0 : consumed_q;
    limit_d       = start_packet_i ? remaining_length_i : limit_q;
    high_cur      = start_packet_i ? 8'd0 : high_q;
    id_cur        = start_packet_i ? 16'd0 : id_q;

    consumed_inc = (consumed_cur == COUNT_MAX) ? consumed_cur : consumed_cur + 1'b1;
    reached      = (consumed_inc >= limit_d);
    word         = {high_cur, data_byte_i};
    field_dec    = (field_cnt_cur != 16'd0) ? field_cnt_cur - 16'd1 : field_cnt_cur;

    phase_d     = phase_cur;
    field_cnt_d = field_cnt_cur;
    consumed_d  = consumed_cur;
    high_d      = high_cur;
    id_d        = id_cur;

    result_o              = '0;
    result_o.kind         = KIND_IGN;
    result_o.error_code   = ERR_NONE;

    case (phase_cur)
      PH_ID_HI: begin
        result_o.kind = KIND_ID;
        high_d        = data_byte_i;
        consumed_d    = consumed_inc;
        phase_d       = PH_ID_LO;
      end
      PH_ID_LO: begin
        result_o.kind = KIND_ID;
        id_d          = word;
        consumed_d    = consumed_inc;
        if (reached) begin
          result_o.error_code = ERR_NO_PAYLOAD;
          phase_d             = PH_HALT;
        end else begin
          phase_d = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        result_o.kind = KIND_LEN;
        high_d        = data_byte_i;
        consumed_d    = consumed_inc;
        phase_d       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        result_o.kind         = KIND_LEN;
        result_o.topic_length = word;
        consumed_d            = consumed_inc;
        // zero length takes priority over the overflow check
        if (word == 16'd0) begin
          result_o.error_code = ERR_ZERO_LEN;
          phase_d             = PH_HALT;
        end else if (reached) begin
          result_o.error_code = ERR_OVERFLOW;
          phase_d             = PH_HALT;
        end else begin
          field_cnt_d = word;
          phase_d     = PH_TOPIC;
        end
      end
      PH_TOPIC: begin
        result_o.kind       = KIND_CHAR;
        result_o.topic_char = data_byte_i;
        consumed_d          = consumed_inc;
        field_cnt_d         = field_dec;
        if (field_dec == 16'd0) begin
          result_o.topic_last = 1'b1;
          phase_d             = PH_QOS;
        end
      end
      PH_QOS: begin
        result_o.kind = KIND_QOS;
        consumed_d    = consumed_inc;
        if (data_byte_i > QOS_MAX) begin
          result_o.qos_value    = QOS_ZERO;
          result_o.qos_replaced = 1'b1;
        end else begin
          result_o.qos_value = data_byte_i[1:0];
        end
        if (reached) begin
          result_o.packet_done = 1'b1;
          phase_d              = PH_HALT;
        end else begin
          phase_d = PH_LEN_HI;
        end
      end
      default: begin
        result_o.kind       = KIND_IGN;
        result_o.error_code = ERR_IGNORED;
      end
    endcase

    result_o.packet_id = id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      field_cnt_q <= 16'd0;
      consumed_q  <= '0;
      limit_q     <= '0;
      high_q      <= 8'd0;
      id_q        <= 16'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      field_cnt_q <= field_cnt_d;
      consumed_q  <= consumed_d;
      limit_q     <= limit_d;
      high_q      <= high_d;
      id_q        <= id_d;
    end
  end

endmodule

### rtl/mspp_queue.sv
`timescale 1ns / 1ps
// Short result queue between the front parser and the output stage.
// Depends on mspp_pkg for the result record and queue depth.
module mspp_queue import mspp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  result_t   push_data_i,
  input  logic      pop_i,
  output result_t   pop_data_o,
  output q_status_t status_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/mspp_back.sv
`timescale 1ns / 1ps
// Output stage: pulls results from the queue into the output register.
// Depends on mspp_pkg for the result record and queue status.
module mspp_back import mspp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t status_i,
  input  result_t   data_i,
  output logic      pop_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output result_t   out_data_o
);

  logic    valid_q;
  result_t data_q;

  // Refill when the register is empty or its item leaves this cycle.
  assign pop_o       = !status_i.empty && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_i;
    end
  end

endmodule

### rtl/mqtt_subscribe_payload_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the SUBSCRIBE variable-header and payload parser.
// Depends on mspp_pkg, mspp_front, mspp_queue and mspp_back.
//
// Usage:
//   Input channel: one raw byte per item (data_byte_i), with start_packet_i
//   marking the first byte of a packet and remaining_length_i sampled on it.
//   An item is taken on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: one classified result per input item, taken on an edge
//   with out_valid_o high and out_stall_i low; while stalled it holds.
//   Path: an accepted item is classified by the front parser and pushed into
//   the queue, then moved into the output register once that register is
//   empty or its item leaves, so it can then be taken on the outputs.
//   Throughput: one item per cycle while in_stall_o is low, limited by
//   the front parser's single 28-bit byte-count increment and compare
//   against the packet length. A four-entry queue decouples the parser
//   from the output register, so the parser keeps taking bytes while a
//   finished result waits; in_stall_o rises only once the queue is full.
//   Reset (rst_ni low, asynchronous) returns the parser to idle, empties the
//   queue and drops the output valid. Bytes before the first start byte and
//   after a packet ends or fails come out as ignored items.
module mqtt_subscribe_payload_parser_unit import mspp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             start_packet_i,
  input  logic [LEN_W-1:0] remaining_length_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       byte_kind_o,
  output logic [7:0]       topic_char_o,
  output logic             topic_last_o,
  output logic [15:0]      topic_length_o,
  output logic [15:0]      packet_id_o,
  output logic [1:0]       qos_value_o,
  output logic             qos_replaced_o,
  output logic [2:0]       error_code_o,
  output logic             packet_done_o
);

  logic      in_accept;
  logic      pop;
  result_t   front_res;
  result_t   q_data;
  result_t   out_res;
  q_status_t q_stat;

  // Stall the source only when the queue has no room.
  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !q_stat.full;

  mspp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .start_packet_i     (start_packet_i),
    .remaining_length_i (remaining_length_i),
    .data_byte_i        (data_byte_i),
    .result_o           (front_res)
  );

  mspp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_res),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .status_o    (q_stat)
  );

  mspp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (q_stat),
    .data_i      (q_data),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res)
  );

  // Unpack the registered result onto the field ports.
  assign byte_kind_o    = out_res.kind;
  assign topic_char_o   = out_res.topic_char;
  assign topic_last_o   = out_res.topic_last;
  assign topic_length_o = out_res.topic_length;
  assign packet_id_o    = out_res.packet_id;
  assign qos_value_o    = out_res.qos_value;
  assign qos_replaced_o = out_res.qos_replaced;
  assign error_code_o   = out_res.error_code;
  assign packet_done_o  = out_res.packet_done;

`ifndef NO_ASSERTIONS
  // An item entering an empty path passes through the queue into the output register and then shows on the outputs.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && q_stat.empty && !out_valid_o) |=> ##1 out_valid_o)
    else $error("item did not reach the output register in time");

  // Ignored bytes and the ignored error code always go together.
  a_ignore_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_res.kind == KIND_IGN) == (out_res.error_code == ERR_IGNORED)))
    else $error("ignored kind and ignored error disagree");

  // A completed packet never carries an error.
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res.packet_done) |->
      (out_res.error_code == ERR_NONE && out_res.kind == KIND_QOS))
    else $error("packet done flagged on a non-qos or errored item");
`endif

endmodule
